// ----- rtl/column_to_row_span_generator_macros.svh -----
`ifndef COLUMN_TO_ROW_SPAN_GENERATOR_MACROS_SVH
`define COLUMN_TO_ROW_SPAN_GENERATOR_MACROS_SVH

// checked only outside reset
`define CRSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define CRSG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/crsg_pkg.sv -----
package crsg_pkg;

  localparam int ROWS  = 64;
  localparam int ROW_W = 6;
  localparam int TOP_W = 7;
  localparam int COL_W = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK_A,
    ST_RUN_A,
    ST_SEEK_B,
    ST_RUN_B,
    ST_OPEN
  } state_t;

  typedef struct packed {
    logic             fwd;
    logic             bwd;
    logic             open;
    logic [ROW_W-1:0] head;
    logic [COL_W-1:0] x;
    logic             c_en;
    logic [ROW_W-1:0] c_lo;
    logic [ROW_W-1:0] c_hi;
    logic             d_en;
    logic [ROW_W-1:0] d_lo;
    logic [ROW_W-1:0] d_hi;
  } ctrl_t;

endpackage

// ----- rtl/crsg_cell.sv -----
module crsg_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [crsg_pkg::ROW_W-1:0]  pos,
  input  crsg_pkg::ctrl_t             ctrl,
  input  logic [crsg_pkg::COL_W-1:0]  from_next,
  input  logic [crsg_pkg::COL_W-1:0]  from_prev,
  output logic [crsg_pkg::COL_W-1:0]  start
);

  logic [crsg_pkg::ROW_W-1:0] cell_row;
  logic                       hit_c;
  logic                       hit_d;

  // row held here follows the head of the ring
  assign cell_row = ctrl.head + pos;
  assign hit_c = ctrl.c_en && (cell_row >= ctrl.c_lo) && (cell_row <= ctrl.c_hi);
  assign hit_d = ctrl.d_en && (cell_row >= ctrl.d_lo) && (cell_row <= ctrl.d_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
    end else if (ctrl.open && (hit_c || hit_d)) begin
      start <= ctrl.x;
    end else if (ctrl.fwd) begin
      start <= from_next;
    end else if (ctrl.bwd) begin
      start <= from_prev;
    end
  end

endmodule

// ----- rtl/crsg_ctrl.sv -----
module crsg_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [crsg_pkg::COL_W-1:0]  column,
  input  logic [crsg_pkg::TOP_W-1:0]  prev_top,
  input  logic [crsg_pkg::ROW_W-1:0]  prev_bottom,
  input  logic [crsg_pkg::TOP_W-1:0]  cur_top,
  input  logic [crsg_pkg::ROW_W-1:0]  cur_bottom,
  input  logic [crsg_pkg::COL_W-1:0]  head_start,
  output crsg_pkg::ctrl_t             ctrl,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [crsg_pkg::ROW_W-1:0]  row,
  output logic [crsg_pkg::COL_W-1:0]  span_begin,
  output logic [crsg_pkg::COL_W-1:0]  span_end,
  output logic                        last
);

  localparam logic [crsg_pkg::TOP_W-1:0] ROWS_T = crsg_pkg::TOP_W'(crsg_pkg::ROWS);
  localparam logic [crsg_pkg::TOP_W-1:0] ONE_T  = crsg_pkg::TOP_W'(1);

  crsg_pkg::state_t state;
  crsg_pkg::state_t state_next;

  logic [crsg_pkg::ROW_W-1:0] head;
  logic [crsg_pkg::COL_W-1:0] x;
  logic [crsg_pkg::ROW_W-1:0] a_lo;
  logic [crsg_pkg::ROW_W-1:0] a_hi;
  logic [crsg_pkg::ROW_W-1:0] b_lo;
  logic [crsg_pkg::ROW_W-1:0] b_hi;
  logic                       b_en;
  logic                       c_en;
  logic [crsg_pkg::ROW_W-1:0] c_lo;
  logic [crsg_pkg::ROW_W-1:0] c_hi;
  logic                       d_en;
  logic [crsg_pkg::ROW_W-1:0] d_lo;
  logic [crsg_pkg::ROW_W-1:0] d_hi;

  // request decode
  logic [crsg_pkg::TOP_W-1:0] t1, b1, t2, b2;
  logic [crsg_pkg::TOP_W-1:0] dq_a_hi, t1n, dq_b_lo, b1n, dq_c_hi, t2n, dq_d_lo;
  logic                       dq_a_en, dq_b_en, dq_c_en, dq_d_en;

  logic                       fwd, bwd, open, emit, emit_last, out_free;
  logic [crsg_pkg::ROW_W-1:0] seek_tgt;
  logic [crsg_pkg::ROW_W-1:0] diff;

  always_comb begin
    t1 = (prev_top >= ROWS_T) ? ROWS_T : prev_top;
    t2 = (cur_top >= ROWS_T) ? ROWS_T : cur_top;
    b1 = {1'b0, prev_bottom};
    b2 = {1'b0, cur_bottom};
    if (b1 >= ROWS_T) b1 = ROWS_T - ONE_T;
    if (b2 >= ROWS_T) b2 = ROWS_T - ONE_T;

    dq_a_en = (t1 < t2) && (t1 <= b1);
    dq_a_hi = ((t2 - ONE_T) < b1) ? (t2 - ONE_T) : b1;
    t1n     = dq_a_en ? (dq_a_hi + ONE_T) : t1;

    dq_b_en = (b1 > b2) && (b1 >= t1n);
    dq_b_lo = ((b2 + ONE_T) > t1n) ? (b2 + ONE_T) : t1n;
    b1n     = dq_b_en ? (dq_b_lo - ONE_T) : b1;

    dq_c_en = (t2 < t1n) && (t2 <= b2);
    dq_c_hi = ((t1n - ONE_T) < b2) ? (t1n - ONE_T) : b2;
    t2n     = dq_c_en ? (dq_c_hi + ONE_T) : t2;

    dq_d_en = (b2 > b1n) && (b2 >= t2n);
    dq_d_lo = ((b1n + ONE_T) > t2n) ? (b1n + ONE_T) : t2n;
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == crsg_pkg::ST_IDLE);
  assign seek_tgt = (state == crsg_pkg::ST_SEEK_A) ? a_lo : b_hi;
  assign diff     = seek_tgt - head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fwd        = 1'b0;
    bwd        = 1'b0;
    open       = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    case (state)
      crsg_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (dq_a_en) begin
            state_next = crsg_pkg::ST_SEEK_A;
          end else if (dq_b_en) begin
            state_next = crsg_pkg::ST_SEEK_B;
          end else begin
            state_next = crsg_pkg::ST_OPEN;
          end
        end
      end
      crsg_pkg::ST_SEEK_A, crsg_pkg::ST_SEEK_B: begin
        if (diff == '0) begin
          state_next = (state == crsg_pkg::ST_SEEK_A) ? crsg_pkg::ST_RUN_A
                                                       : crsg_pkg::ST_RUN_B;
        end else if (!diff[crsg_pkg::ROW_W-1]) begin
          fwd = 1'b1;
        end else begin
          bwd = 1'b1;
        end
      end
      crsg_pkg::ST_RUN_A: begin
        if (out_free) begin
          emit = 1'b1;
          if (head == a_hi) begin
            emit_last  = !b_en;
            state_next = b_en ? crsg_pkg::ST_SEEK_B : crsg_pkg::ST_OPEN;
          end else begin
            fwd = 1'b1;
          end
        end
      end
      crsg_pkg::ST_RUN_B: begin
        if (out_free) begin
          emit = 1'b1;
          if (head == b_lo) begin
            emit_last  = 1'b1;
            state_next = crsg_pkg::ST_OPEN;
          end else begin
            bwd = 1'b1;
          end
        end
      end
      crsg_pkg::ST_OPEN: begin
        open       = 1'b1;
        state_next = crsg_pkg::ST_IDLE;
      end
      default: begin
        state_next = crsg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (fwd) begin
      head <= head + crsg_pkg::ROW_W'(1);
    end else if (bwd) begin
      head <= head - crsg_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x    <= column;
      a_lo <= t1[crsg_pkg::ROW_W-1:0];
      a_hi <= dq_a_hi[crsg_pkg::ROW_W-1:0];
      b_en <= dq_b_en;
      b_lo <= dq_b_lo[crsg_pkg::ROW_W-1:0];
      b_hi <= b1[crsg_pkg::ROW_W-1:0];
      c_en <= dq_c_en;
      c_lo <= t2[crsg_pkg::ROW_W-1:0];
      c_hi <= dq_c_hi[crsg_pkg::ROW_W-1:0];
      d_en <= dq_d_en;
      d_lo <= dq_d_lo[crsg_pkg::ROW_W-1:0];
      d_hi <= b2[crsg_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row        <= head;
      span_begin <= head_start;
      span_end   <= x;
      last       <= emit_last;
    end
  end

  always_comb begin
    ctrl.fwd  = fwd;
    ctrl.bwd  = bwd;
    ctrl.open = open;
    ctrl.head = head;
    ctrl.x    = x;
    ctrl.c_en = c_en;
    ctrl.c_lo = c_lo;
    ctrl.c_hi = c_hi;
    ctrl.d_en = d_en;
    ctrl.d_lo = d_lo;
    ctrl.d_hi = d_hi;
  end

endmodule

// ----- rtl/column_to_row_span_generator.sv -----
// steps: take a request, rotate the row ring to the first closing row, emit the top run's
// spans, seek the bottom run and emit its spans, then open newly covered rows; an empty run
// is skipped; spans go out one per cycle while the output is free, and a new column is taken
// only in idle, after the last is done; the ring of row cells moves at most one row per cycle
// reset: synchronous; all row starts clear to zero, ring head at row 0, no span pending
module column_to_row_span_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [crsg_pkg::COL_W-1:0]  column,
  input  logic [crsg_pkg::TOP_W-1:0]  prev_top,
  input  logic [crsg_pkg::ROW_W-1:0]  prev_bottom,
  input  logic [crsg_pkg::TOP_W-1:0]  cur_top,
  input  logic [crsg_pkg::ROW_W-1:0]  cur_bottom,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [crsg_pkg::ROW_W-1:0]  row,
  output logic [crsg_pkg::COL_W-1:0]  span_begin,
  output logic [crsg_pkg::COL_W-1:0]  span_end,
  output logic                        last
);

  localparam int CELLS = crsg_pkg::ROWS;

  crsg_pkg::ctrl_t            ctrl;
  logic [crsg_pkg::COL_W-1:0] starts [CELLS];

  crsg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .column      (column),
    .prev_top    (prev_top),
    .prev_bottom (prev_bottom),
    .cur_top     (cur_top),
    .cur_bottom  (cur_bottom),
    .head_start  (starts[0]),
    .ctrl        (ctrl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row         (row),
    .span_begin  (span_begin),
    .span_end    (span_end),
    .last        (last)
  );

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    localparam int NEXT = (k + 1) % CELLS;
    localparam int PREV = (k + CELLS - 1) % CELLS;
    crsg_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .pos       (crsg_pkg::ROW_W'(k)),
      .ctrl      (ctrl),
      .from_next (starts[NEXT]),
      .from_prev (starts[PREV]),
      .start     (starts[k])
    );
  end

endmodule

// ----- rtl/crsg_checker.sv -----
`include "column_to_row_span_generator_macros.svh"

module crsg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [crsg_pkg::ROW_W-1:0]  row,
  input logic [crsg_pkg::COL_W-1:0]  span_begin,
  input logic [crsg_pkg::COL_W-1:0]  span_end,
  input logic                        last
);

  logic [crsg_pkg::ROW_W+2*crsg_pkg::COL_W:0] span_bits;

  assign span_bits = {row, span_begin, span_end, last};

  `CRSG_ASSERT(a_busy_after_req, (in_valid && in_ready) |=> !in_ready, "ready after request")
  `CRSG_ASSERT(a_idle_only_last, (in_ready && out_valid) |-> last, "idle with open column")
  `CRSG_ASSERT(a_stall_valid, (out_valid && !out_ready) |=> out_valid, "stalled span dropped")
  `CRSG_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> $stable(span_bits), "span changed")
  `CRSG_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "span after reset")

endmodule

bind column_to_row_span_generator crsg_checker u_crsg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .row        (row),
  .span_begin (span_begin),
  .span_end   (span_end),
  .last       (last)
);

// ----- verif/column_to_row_span_generator_checker.sv -----
`timescale 1ns / 100ps
module column_to_row_span_generator_checker
  import crsg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [COL_W-1:0] column,
  input  logic [TOP_W-1:0] prev_top,
  input  logic [ROW_W-1:0] prev_bottom,
  input  logic [TOP_W-1:0] cur_top,
  input  logic [ROW_W-1:0] cur_bottom,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [ROW_W-1:0] row,
  input  logic [COL_W-1:0] span_begin,
  input  logic [COL_W-1:0] span_end,
  input  logic             last,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] first_col;
    logic [COL_W-1:0] end_col;
    logic             last;
  } span_t;

  logic [COL_W-1:0] row_start [ROWS];
  span_t            span_q [$];
  span_t            want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_span(input int r, input logic [COL_W-1:0] x);
    span_t s;
    s.row       = r[ROW_W-1:0];
    s.first_col = row_start[r];
    s.end_col   = x;
    s.last      = 1'b0;
    span_q.insert(span_q.size(), s);
  endtask

  // closing rows produce spans, newly covered rows latch the column
  task automatic predict_spans(input logic [COL_W-1:0] x, input logic [TOP_W-1:0] pt,
                               input logic [ROW_W-1:0] pb, input logic [TOP_W-1:0] ct,
                               input logic [ROW_W-1:0] cb);
    int old_top, old_bot, new_top, new_bot, n;
    old_top = (pt >= ROWS) ? ROWS : int'(pt);
    old_bot = (pb >= ROWS) ? ROWS - 1 : int'(pb);
    new_top = (ct >= ROWS) ? ROWS : int'(ct);
    new_bot = (cb >= ROWS) ? ROWS - 1 : int'(cb);
    n = 0;
    while (old_top < new_top && old_top <= old_bot) begin
      push_span(old_top, x);
      old_top++;
      n++;
    end
    while (old_bot > new_bot && old_bot >= old_top) begin
      push_span(old_bot, x);
      old_bot--;
      n++;
    end
    while (new_top < old_top && new_top <= new_bot) begin
      row_start[new_top] = x;
      new_top++;
    end
    while (new_bot > old_bot && new_bot >= new_top) begin
      row_start[new_bot] = x;
      new_bot--;
    end
    if (n > 0) span_q[span_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) row_start[r] = '0;
      span_q.delete();
    end else begin
      // a span accepted now always belongs to an earlier request
      if (out_valid && out_ready) begin
        if (span_q.size() == 0) begin
          report_mismatch($sformatf("span for row %0d with nothing pending", row));
        end else begin
          want = span_q.pop_front();
          if (row !== want.row)
            report_mismatch($sformatf("row got %0d want %0d", row, want.row));
          if (span_begin !== want.first_col)
            report_mismatch($sformatf("row %0d span_begin got %0d want %0d",
                                      want.row, span_begin, want.first_col));
          if (span_end !== want.end_col)
            report_mismatch($sformatf("row %0d span_end got %0d want %0d",
                                      want.row, span_end, want.end_col));
          if (last !== want.last)
            report_mismatch($sformatf("row %0d last got %0b want %0b",
                                      want.row, last, want.last));
        end
      end
      if (in_valid && in_ready)
        predict_spans(column, prev_top, prev_bottom, cur_top, cur_bottom);
    end
    pending = span_q.size();
  end

endmodule

// ----- verif/column_to_row_span_generator_tb.sv -----
`timescale 1ns / 100ps
module column_to_row_span_generator_tb;
  import crsg_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int TAIL_CYCLES    = 300;
  localparam int RANDOM_COLUMNS = 180;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [COL_W-1:0] column      = '0;
  logic [TOP_W-1:0] prev_top    = '0;
  logic [ROW_W-1:0] prev_bottom = '0;
  logic [TOP_W-1:0] cur_top     = '0;
  logic [ROW_W-1:0] cur_bottom  = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] span_begin;
  logic [COL_W-1:0] span_end;
  logic             last;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int ready_hold  = 0;
  int ready_pick;
  int burst_left  = 0;
  int walk_x, walk_top, walk_bottom, next_top, next_bottom;

  column_to_row_span_generator dut (
    .clk, .rst, .in_valid, .in_ready, .column, .prev_top, .prev_bottom, .cur_top,
    .cur_bottom, .out_valid, .out_ready, .row, .span_begin, .span_end, .last
  );

  column_to_row_span_generator_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .column, .prev_top, .prev_bottom, .cur_top,
    .cur_bottom, .out_valid, .out_ready, .row, .span_begin, .span_end, .last,
    .fail_count, .pending
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_pick = $urandom_range(0, 9);
      if (ready_pick < 4) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(1, 30);
      end else if (ready_pick < 8) begin
        out_ready <= ready_pick[0];
        ready_hold = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end else begin
      ready_hold--;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int step_row(input int r);
    int n;
    n = r + int'($urandom_range(0, 8)) - 4;
    return (n < 0) ? 0 : ((n > ROWS - 1) ? ROWS - 1 : n);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_column(input int x, input int pt, input int pb, input int ct, input int cb);
    int gap;
    column      <= x[COL_W-1:0];
    prev_top    <= pt[TOP_W-1:0];
    prev_bottom <= pb[ROW_W-1:0];
    cur_top     <= ct[TOP_W-1:0];
    cur_bottom  <= cb[ROW_W-1:0];
    in_valid    <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if (gap < 9) gap = 0;
      else if (gap < 17) gap = $urandom_range(1, 3);
      else if (gap < 19) gap = $urandom_range(8, 40);
      else begin
        burst_left = $urandom_range(10, 30);
        gap = 0;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_column(0, 64, 0, 0, 63);
    send_column(512, 0, 63, 64, 0);
    send_column(1, 127, 63, 10, 50);
    send_column(2, 10, 50, 20, 40);
    send_column(3, 20, 40, 20, 40);
    send_column(1023, 20, 40, 5, 60);
    send_column(700, 5, 60, 30, 35);
    send_column(4, 30, 35, 40, 10);
    send_column(5, 64, 0, 0, 0);
    send_column(6, 0, 0, 63, 63);
    send_column(7, 63, 63, 64, 63);
    send_column(8, 100, 20, 40, 10);
    send_column(9, 0, 63, 0, 63);
    send_column(10, 0, 10, 30, 40);
    send_column(11, 30, 40, 0, 10);
    send_column(12, 0, 10, 127, 0);
    send_column(1023, 64, 63, 127, 63);
    send_column(341, 85, 42, 42, 21);

    // let every span drain before the random walk starts
    wait_drained();

    walk_x      = $urandom_range(0, 1023);
    walk_top    = ROWS;
    walk_bottom = 0;
    for (int i = 0; i < RANDOM_COLUMNS; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        send_column($urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 63),
                    $urandom_range(0, 127), $urandom_range(0, 63));
      end else begin
        if (walk_top >= ROWS || $urandom_range(0, 7) == 0) begin
          next_top    = $urandom_range(0, ROWS - 1);
          next_bottom = $urandom_range(next_top, ROWS - 1);
        end else begin
          next_top    = step_row(walk_top);
          next_bottom = step_row(walk_bottom);
          if (next_bottom < next_top) next_bottom = next_top;
        end
        if ($urandom_range(0, 11) == 0) next_top = $urandom_range(ROWS, 127);
        send_column(walk_x, walk_top, walk_bottom, next_top, next_bottom);
        walk_x      = (walk_x + 1) % 1024;
        walk_top    = next_top;
        walk_bottom = next_bottom;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
